@@ rtl/uts_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal sanitiser: shared package
// Constants, the result plan record and the code point helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package uts_pkg;

   // Bytes of U+FFFD in UTF-8.
   localparam logic [7:0] FFFD_B0 = 8'hEF;
   localparam logic [7:0] FFFD_B1 = 8'hBF;
   localparam logic [7:0] FFFD_B2 = 8'hBD;

   localparam logic [20:0] CODE_MAX = 21'h10FFFF;
   localparam logic [20:0] SURR_LO  = 21'h00D800;
   localparam logic [20:0] SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] CODE_DEL = 21'h00007F;

   localparam logic [7:0] CHR_BSL = 8'h5C;   // backslash
   localparam logic [7:0] CHR_N   = 8'h6E;
   localparam logic [7:0] CHR_R   = 8'h72;
   localparam logic [7:0] CHR_T   = 8'h74;
   localparam logic [7:0] CHR_X   = 8'h78;
   localparam logic [7:0] CHR_U   = 8'h75;
   localparam logic [7:0] CHR_0   = 8'h30;

   localparam int TAIL_MAX = 6;

   // Everything one request produces: a run of U+FFFD, then an optional tail
   // that is either an escape or the original bytes of a code point.
   typedef struct packed {
      logic [2:0]                   fffd_cnt;
      logic [2:0]                   tail_len;
      logic [TAIL_MAX-1:0][7:0]     tail_byte;
      logic [TAIL_MAX-1:0][1:0]     tail_wid;
      logic                         last;
   } plan_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) r = 8'h30 + {4'b0, v};
      else           r = 8'h37 + {4'b0, v};
      return r;
   endfunction

   function automatic logic [1:0] cp_width(input logic [20:0] c);
      logic zero_w;
      logic wide_w;
      zero_w = (c == 21'h0) ||
               (c >= 21'h0300 && c <= 21'h036F) || (c >= 21'h1AB0 && c <= 21'h1AFF) ||
               (c >= 21'h1DC0 && c <= 21'h1DFF) || (c >= 21'h20D0 && c <= 21'h20FF) ||
               (c >= 21'hFE00 && c <= 21'hFE0F);
      wide_w = (c >= 21'h1100 && c <= 21'h115F) || (c >= 21'h2329 && c <= 21'h232A) ||
               (c >= 21'h2E80 && c <= 21'hA4CF) || (c >= 21'hAC00 && c <= 21'hD7A3) ||
               (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'hFE10 && c <= 21'hFE19) ||
               (c >= 21'hFE30 && c <= 21'hFE6F) || (c >= 21'hFF00 && c <= 21'hFF60) ||
               (c >= 21'hFFE0 && c <= 21'hFFE6) ||
               (c >= 21'h1F300 && c <= 21'h1FAFF) ||
               (c >= 21'h20000 && c <= 21'h3FFFD);
      if (zero_w)      return 2'd0;
      else if (wide_w) return 2'd2;
      else             return 2'd1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/uts_channels.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal sanitiser: channel interfaces
// Valid/ready channels for raw text bytes and for sanitised result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface uts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       text_end;

   modport source (output valid, output in_byte, output text_end, input ready);
   modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface uts_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        run_last;
   logic        text_done;
   logic [15:0] width_total;

   modport source (output valid, output out_byte, output run_last, output text_done,
                   output width_total, input ready);
   modport sink   (input valid, input out_byte, input run_last, input text_done,
                   input width_total, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8_terminal_sanitizer_unit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal sanitiser
// Decodes and checks UTF-8, escapes control characters and tracks display width.
// ----------------------------------------------------------------------------
// Path: input register, then plan register, then result register.
// Throughput: a request is taken every cycle unless its plan must wait for the
// emitter, which sends one byte per cycle while the result channel takes it; a
// request makes up to 13 result bytes, and one that is only buffered does not wait.
// Reset: synchronous; clears the decoder, the width total and all valid flags.
`default_nettype none

module utf8_terminal_sanitizer_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   uts_req_if.sink    req_chan,
   uts_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {PH_EF, PH_BF, PH_BD} fffd_phase_type;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Decoder state.
   logic [2:0]       seq_len_ff,  seq_len_in;
   logic [1:0]       held_cnt_ff, held_cnt_in;
   logic [20:0]      accum_ff,    accum_in;
   logic [2:0][7:0]  held_ff,     held_in;

   // Plan register and emitter.
   logic                 plan_valid_ff;
   uts_pkg::plan_type    plan_ff, plan_in;
   logic [2:0]           fffd_left_ff;
   fffd_phase_type       phase_ff;
   logic [2:0]           tail_idx_ff;
   logic [15:0]          wsum_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_run_last_ff;
   logic        rsp_done_ff;
   logic [15:0] rsp_width_ff;

   // Decode signals.
   logic             pending, is_cont, complete, code_bad, cp_ok, plan_has;
   logic [20:0]      acc_next, cp_code;
   logic [2:0]       fffd_n, raw_n;
   logic [1:0]       raw_last;
   logic [3:0][7:0]  raw;
   logic             dec_fire, plan_free;

   // Emitter signals.
   logic        emit_fire, emit_last;
   logic [7:0]  emit_byte;
   logic [1:0]  emit_wid;
   logic [16:0] wsum_add;
   logic [15:0] wsum_sat;

   assign req_chan.ready = !in_valid_ff || dec_fire;

   assign pending  = seq_len_ff != 3'd0;
   assign is_cont  = in_byte_ff[7:6] == 2'b10;
   assign acc_next = {accum_ff[14:0], in_byte_ff[5:0]};
   assign complete = ({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff;
   assign code_bad = (seq_len_ff == 3'd2 && acc_next < 21'h80) ||
                     (seq_len_ff == 3'd3 && acc_next < 21'h800) ||
                     (seq_len_ff == 3'd4 && acc_next < 21'h10000) ||
                     (acc_next >= uts_pkg::SURR_LO && acc_next <= uts_pkg::SURR_HI) ||
                     acc_next > uts_pkg::CODE_MAX;

   // Sequence decoding and the state it leaves behind.
   always_comb begin
      seq_len_in  = seq_len_ff;
      held_cnt_in = held_cnt_ff;
      accum_in    = accum_ff;
      held_in     = held_ff;
      fffd_n      = 3'd0;
      cp_ok       = 1'b0;
      cp_code     = {13'b0, in_byte_ff};
      raw_n       = 3'd1;
      raw_last    = 2'd0;
      if (!pending || !is_cont) begin
         // An interrupted sequence gives one replacement per held byte.
         if (pending) fffd_n = {1'b0, held_cnt_ff};
         seq_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         accum_in    = '0;
         if (!in_byte_ff[7]) begin
            cp_ok = 1'b1;
         end else if (in_byte_ff[7:5] == 3'b110) begin
            seq_len_in  = 3'd2;
            accum_in    = {16'b0, in_byte_ff[4:0]};
            held_cnt_in = 2'd1;
            held_in[0]  = in_byte_ff;
         end else if (in_byte_ff[7:4] == 4'b1110) begin
            seq_len_in  = 3'd3;
            accum_in    = {17'b0, in_byte_ff[3:0]};
            held_cnt_in = 2'd1;
            held_in[0]  = in_byte_ff;
         end else if (in_byte_ff[7:3] == 5'b11110) begin
            seq_len_in  = 3'd4;
            accum_in    = {18'b0, in_byte_ff[2:0]};
            held_cnt_in = 2'd1;
            held_in[0]  = in_byte_ff;
         end else begin
            fffd_n = fffd_n + 3'd1;
         end
      end else if (complete) begin
         seq_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         accum_in    = '0;
         if (code_bad) begin
            fffd_n = {1'b0, held_cnt_ff} + 3'd1;
         end else begin
            cp_ok    = 1'b1;
            cp_code  = acc_next;
            raw_n    = {1'b0, held_cnt_ff} + 3'd1;
            raw_last = held_cnt_ff;
         end
      end else begin
         accum_in             = acc_next;
         held_in[held_cnt_ff] = in_byte_ff;
         held_cnt_in          = held_cnt_ff + 2'd1;
      end
      // A sequence still open at the end of the text is cut off.
      if (in_last_ff) begin
         if (seq_len_in != 3'd0) fffd_n = fffd_n + {1'b0, held_cnt_in};
         seq_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         accum_in    = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         raw[i] = (2'(i) == raw_last) ? in_byte_ff : held_ff[i];
      end
      raw[3] = in_byte_ff;
   end

   // Escape or pass-through tail of the plan.
   always_comb begin
      plan_in           = '0;
      plan_in.fffd_cnt  = fffd_n;
      plan_in.last      = in_last_ff;
      if (cp_ok) begin
         if (cp_code == 21'h0A || cp_code == 21'h0D || cp_code == 21'h09) begin
            plan_in.tail_len     = 3'd2;
            plan_in.tail_byte[0] = uts_pkg::CHR_BSL;
            if (cp_code == 21'h0A)      plan_in.tail_byte[1] = uts_pkg::CHR_N;
            else if (cp_code == 21'h0D) plan_in.tail_byte[1] = uts_pkg::CHR_R;
            else                        plan_in.tail_byte[1] = uts_pkg::CHR_T;
            plan_in.tail_wid[0] = 2'd1;
            plan_in.tail_wid[1] = 2'd1;
         end else if (cp_code < 21'h20 || cp_code == uts_pkg::CODE_DEL) begin
            plan_in.tail_len     = 3'd4;
            plan_in.tail_byte[0] = uts_pkg::CHR_BSL;
            plan_in.tail_byte[1] = uts_pkg::CHR_X;
            plan_in.tail_byte[2] = uts_pkg::hex_char(cp_code[7:4]);
            plan_in.tail_byte[3] = uts_pkg::hex_char(cp_code[3:0]);
            for (int i = 0; i < 4; i++) plan_in.tail_wid[i] = 2'd1;
         end else if (cp_code >= 21'h80 && cp_code <= 21'h9F) begin
            plan_in.tail_len     = 3'd6;
            plan_in.tail_byte[0] = uts_pkg::CHR_BSL;
            plan_in.tail_byte[1] = uts_pkg::CHR_U;
            plan_in.tail_byte[2] = uts_pkg::CHR_0;
            plan_in.tail_byte[3] = uts_pkg::CHR_0;
            plan_in.tail_byte[4] = uts_pkg::hex_char(cp_code[7:4]);
            plan_in.tail_byte[5] = uts_pkg::hex_char(cp_code[3:0]);
            for (int i = 0; i < 6; i++) plan_in.tail_wid[i] = 2'd1;
         end else begin
            plan_in.tail_len = raw_n;
            for (int i = 0; i < 4; i++) plan_in.tail_byte[i] = raw[i];
            plan_in.tail_wid[raw_n - 3'd1] = uts_pkg::cp_width(cp_code);
         end
      end
   end

   assign plan_has  = (plan_in.fffd_cnt != 3'd0) || (plan_in.tail_len != 3'd0);
   assign plan_free = !plan_valid_ff || (emit_fire && emit_last);
   assign dec_fire  = in_valid_ff && (!plan_has || plan_free);

   // Emitter: replacement characters first, then the tail.
   assign emit_fire = plan_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign emit_last = (fffd_left_ff == 3'd1 && phase_ff == PH_BD &&
                       plan_ff.tail_len == 3'd0) ||
                      (fffd_left_ff == 3'd0 && tail_idx_ff == plan_ff.tail_len - 3'd1);

   always_comb begin
      emit_byte = plan_ff.tail_byte[tail_idx_ff];
      emit_wid  = plan_ff.tail_wid[tail_idx_ff];
      if (fffd_left_ff != 3'd0) begin
         unique case (phase_ff)
            PH_EF:   begin emit_byte = uts_pkg::FFFD_B0; emit_wid = 2'd0; end
            PH_BF:   begin emit_byte = uts_pkg::FFFD_B1; emit_wid = 2'd0; end
            default: begin emit_byte = uts_pkg::FFFD_B2; emit_wid = 2'd1; end
         endcase
      end
   end

   assign wsum_add = {1'b0, wsum_ff} + {15'b0, emit_wid};
   assign wsum_sat = wsum_add[16] ? 16'hFFFF : wsum_add[15:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         seq_len_ff    <= 3'd0;
         held_cnt_ff   <= 2'd0;
         accum_ff      <= '0;
         plan_valid_ff <= 1'b0;
         fffd_left_ff  <= 3'd0;
         phase_ff      <= PH_EF;
         tail_idx_ff   <= 3'd0;
         wsum_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) in_valid_ff <= 1'b1;
         else if (dec_fire)                   in_valid_ff <= 1'b0;

         if (dec_fire) begin
            seq_len_ff  <= seq_len_in;
            held_cnt_ff <= held_cnt_in;
            accum_ff    <= accum_in;
         end

         if (emit_fire) begin
            if (emit_last && plan_ff.last) wsum_ff <= '0;
            else                          wsum_ff <= wsum_sat;
         end

         // A new plan may replace the one whose last byte goes out now.
         if (dec_fire && plan_has) begin
            plan_valid_ff <= 1'b1;
            fffd_left_ff  <= plan_in.fffd_cnt;
            phase_ff      <= PH_EF;
            tail_idx_ff   <= 3'd0;
         end else if (emit_fire) begin
            if (emit_last) plan_valid_ff <= 1'b0;
            if (fffd_left_ff != 3'd0) begin
               unique case (phase_ff)
                  PH_EF:   phase_ff <= PH_BF;
                  PH_BF:   phase_ff <= PH_BD;
                  default: begin
                     phase_ff     <= PH_EF;
                     fffd_left_ff <= fffd_left_ff - 3'd1;
                  end
               endcase
            end else begin
               tail_idx_ff <= tail_idx_ff + 3'd1;
            end
         end

         if (emit_fire)            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)  rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.text_end;
      end
      if (dec_fire) held_ff <= held_in;
      if (dec_fire && plan_has) plan_ff <= plan_in;
      if (emit_fire) begin
         rsp_byte_ff     <= emit_byte;
         rsp_run_last_ff <= emit_last;
         rsp_done_ff     <= emit_last && plan_ff.last;
         rsp_width_ff    <= wsum_sat;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_byte_ff;
   assign rsp_chan.run_last    = rsp_run_last_ff;
   assign rsp_chan.text_done   = rsp_done_ff;
   assign rsp_chan.width_total = rsp_width_ff;

endmodule

`default_nettype wire

@@ rtl/uts_checker.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal sanitiser: port checker
// Watches the top-level ports for reset, ordering and width-total behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_run_last,
   input wire logic        rsp_text_done,
   input wire logic [15:0] rsp_width_total
);

   // Straight after reset nothing is on offer and a request can be taken.
   a_reset_idle : assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("result pending or request refused after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last) &&
          $stable(rsp_text_done) && $stable(rsp_width_total)))
      else $error("stalled result changed");

   // The final result of a text is always the last one of its request.
   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_done) |-> rsp_run_last)
      else $error("text finished before its request's results did");

   // Within a text the width total never falls and grows by at most two a byte.
   a_width_step : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_text_done) |=>
         (!rsp_valid || (rsp_width_total >= $past(rsp_width_total) &&
          {1'b0, rsp_width_total} <= {1'b0, $past(rsp_width_total)} + 17'd2)))
      else $error("width total stepped wrongly");

endmodule

bind utf8_terminal_sanitizer_unit uts_checker u_uts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_run_last    (rsp_chan.run_last),
   .rsp_text_done   (rsp_chan.text_done),
   .rsp_width_total (rsp_chan.width_total)
);

`default_nettype wire

@@ sim/uts_output_checker.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal sanitiser: output checker
// Watches both channels, predicts the sanitised byte stream for every accepted
// request and compares each result byte, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module uts_output_checker (
   input  logic        clock,
   input  logic        reset,
   uts_req_if          req_mon,
   uts_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned req_seen,
   output int unsigned rsp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [20:0] CODE_TAB = 21'h09;
   localparam logic [20:0] CODE_LF  = 21'h0A;
   localparam logic [20:0] CODE_CR  = 21'h0D;

   typedef struct packed {
      logic [7:0]  data;
      logic        run_last;
      logic        text_done;
      logic [15:0] cols;
   } sanitized_byte_type;

   sanitized_byte_type sanitized_q[$];

   // Decoder state of the predicted block.
   logic [7:0]  held [0:3];
   logic [2:0]  seq_len;
   logic [1:0]  held_cnt;
   logic [20:0] accum;
   logic [15:0] width_sum;

   int unsigned fails = 0;
   int unsigned pend  = 0;
   int unsigned reqs  = 0;
   int unsigned rsps  = 0;

   assign fail_count = fails;
   assign pending    = pend;
   assign req_seen   = reqs;
   assign rsp_seen   = rsps;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
   endfunction

   function automatic logic [1:0] column_width(input logic [20:0] c);
      if (c == 21'h0 || c inside {[21'h0300:21'h036F], [21'h1AB0:21'h1AFF],
                                  [21'h1DC0:21'h1DFF], [21'h20D0:21'h20FF],
                                  [21'hFE00:21'hFE0F]})
         return 2'd0;
      if (c inside {[21'h1100:21'h115F], [21'h2329:21'h232A], [21'h2E80:21'hA4CF],
                    [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF], [21'hFE10:21'hFE19],
                    [21'hFE30:21'hFE6F], [21'hFF00:21'hFF60], [21'hFFE0:21'hFFE6],
                    [21'h1F300:21'h1FAFF], [21'h20000:21'h3FFFD]})
         return 2'd2;
      return 2'd1;
   endfunction

   task automatic put(input logic [7:0] b, input logic [1:0] w);
      logic [16:0]        s;
      sanitized_byte_type item;
      s = {1'b0, width_sum} + 17'(w);
      width_sum = s[16] ? 16'hFFFF : s[15:0];
      item = '{data: b, run_last: 1'b0, text_done: 1'b0, cols: width_sum};
      sanitized_q = {sanitized_q, item};
   endtask

   task automatic put_replacement();
      put(uts_pkg::FFFD_B0, 2'd0);
      put(uts_pkg::FFFD_B1, 2'd0);
      put(uts_pkg::FFFD_B2, 2'd1);
   endtask

   task automatic clear_seq();
      seq_len  = 3'd0;
      held_cnt = 2'd0;
      accum    = 21'd0;
   endtask

   // The lead and every held continuation each turn into one replacement.
   task automatic flush_bad();
      for (int i = 0; i < held_cnt; i++) put_replacement();
      clear_seq();
   endtask

   task automatic put_code(input logic [20:0] c, input logic [3:0][7:0] raw,
                           input int unsigned n);
      if (c == CODE_LF) begin
         put(uts_pkg::CHR_BSL, 2'd1); put(uts_pkg::CHR_N, 2'd1);
      end else if (c == CODE_CR) begin
         put(uts_pkg::CHR_BSL, 2'd1); put(uts_pkg::CHR_R, 2'd1);
      end else if (c == CODE_TAB) begin
         put(uts_pkg::CHR_BSL, 2'd1); put(uts_pkg::CHR_T, 2'd1);
      end else if (c < 21'h20 || c == uts_pkg::CODE_DEL) begin
         put(uts_pkg::CHR_BSL, 2'd1); put(uts_pkg::CHR_X, 2'd1);
         put(hex_digit(c[7:4]), 2'd1); put(hex_digit(c[3:0]), 2'd1);
      end else if (c >= 21'h80 && c <= 21'h9F) begin
         put(uts_pkg::CHR_BSL, 2'd1); put(uts_pkg::CHR_U, 2'd1);
         put(uts_pkg::CHR_0, 2'd1); put(uts_pkg::CHR_0, 2'd1);
         put(hex_digit(c[7:4]), 2'd1); put(hex_digit(c[3:0]), 2'd1);
      end else begin
         for (int i = 0; i < n; i++)
            put(raw[i], (i == n - 1) ? column_width(c) : 2'd0);
      end
   endtask

   task automatic start_seq(input logic [7:0] b);
      if (!b[7]) begin
         put_code({13'd0, b}, {24'd0, b}, 1);
         return;
      end
      if (b[7:5] == 3'b110) begin
         seq_len = 3'd2; accum = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         seq_len = 3'd3; accum = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         seq_len = 3'd4; accum = {18'd0, b[2:0]};
      end else begin
         put_replacement();
         return;
      end
      held[0]  = b;
      held_cnt = 2'd1;
   endtask

   task automatic sanitize_request(input logic [7:0] b, input logic last);
      int unsigned        first;
      int unsigned        n;
      logic [20:0]        c;
      logic               bad;
      logic [3:0][7:0]    raw;
      sanitized_byte_type tail;
      first = sanitized_q.size();
      if (seq_len == 3'd0 || held_cnt == 2'd0) begin
         clear_seq();
         start_seq(b);
      end else if (b[7:6] != 2'b10) begin
         flush_bad();
         start_seq(b);
      end else begin
         accum = {accum[14:0], b[5:0]};
         if ({1'b0, held_cnt} + 3'd1 >= seq_len) begin
            c   = accum;
            bad = (seq_len == 3'd2 && c < 21'h80) || (seq_len == 3'd3 && c < 21'h800) ||
                  (seq_len == 3'd4 && c < 21'h10000) ||
                  (c >= uts_pkg::SURR_LO && c <= uts_pkg::SURR_HI) ||
                  c > uts_pkg::CODE_MAX;
            if (bad) begin
               flush_bad();
               put_replacement();
            end else begin
               raw = '0;
               for (int i = 0; i < held_cnt; i++) raw[i] = held[i];
               raw[held_cnt] = b;
               n = held_cnt + 1;
               clear_seq();
               put_code(c, raw, n);
            end
         end else begin
            held[held_cnt] = b;
            held_cnt       = held_cnt + 2'd1;
         end
      end
      if (last && seq_len != 3'd0) flush_bad();
      if (sanitized_q.size() > first) begin
         tail = sanitized_q[sanitized_q.size() - 1];
         tail.run_last  = 1'b1;
         tail.text_done = last;
         sanitized_q[sanitized_q.size() - 1] = tail;
      end
      if (last) begin
         clear_seq();
         width_sum = 16'd0;
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         fails++;
         if (fails <= 40)
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      sanitized_byte_type want;
      if (reset) begin
         clear_seq();
         width_sum = 16'd0;
         sanitized_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            sanitize_request(req_mon.in_byte, req_mon.text_end);
            reqs++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsps++;
            if (sanitized_q.size() == 0) begin
               fails++;
               if (fails <= 40)
                  $display("%0t: result byte 0x%0h arrived with nothing pending",
                           $time, rsp_mon.out_byte);
            end else begin
               want = sanitized_q.pop_front();
               compare_field("out_byte", want.data, rsp_mon.out_byte);
               compare_field("run_last", want.run_last, rsp_mon.run_last);
               compare_field("text_done", want.text_done, rsp_mon.text_done);
               compare_field("width_total", want.cols, rsp_mon.width_total);
            end
         end
      end
      pend = sanitized_q.size();
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// UTF-8 terminal sanitiser: testbench top
// Drives directed texts, random well-formed and malformed UTF-8 texts and one
// short text of C1 escapes, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS  = 130;
   localparam int unsigned C1_PAIRS      = 6;
   localparam int unsigned LATENCY_SLACK = 30;

   typedef struct packed {
      logic [7:0] b;
      logic       fin;
   } text_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic calm  = 1'b0;
   int unsigned sent = 0;
   int unsigned fail_count, pending, req_seen, rsp_seen;

   text_byte_type text_q[$];

   // Directed texts: {text end, byte}.
   logic [8:0] directed_seq [0:24] = '{
      9'h041, 9'h00A, 9'h00D, 9'h009, 9'h000, 9'h17F,   // plain and control bytes
      9'h0C2, 9'h085,                                   // C1 control
      9'h0FF,                                           // bad lead byte
      9'h0C0, 9'h080,                                   // overlong form
      9'h0ED, 9'h0A0, 9'h080,                           // surrogate
      9'h0F4, 9'h090, 9'h080, 9'h080,                   // above the last code point
      9'h0E4, 9'h0B8, 9'h080,                           // wide character
      9'h0C3, 9'h041,                                   // bad continuation
      9'h0F0, 9'h19F                                    // cut off at end of text
   };

   uts_req_if req_chan ();
   uts_rsp_if rsp_chan ();

   utf8_terminal_sanitizer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   uts_output_checker monitor (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .req_seen   (req_seen),
      .rsp_seen   (rsp_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 12);
   end

   task automatic send(input logic [7:0] b, input logic fin);
      while (!calm && $urandom_range(99) < 12) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.in_byte  <= b;
      req_chan.text_end <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
      // One stretch of the random texts runs with no gaps on either side.
      calm <= (sent >= 80 && sent < 140);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   // Appends the first keep bytes of the len-byte encoding of cp.
   task automatic add_code(input logic [20:0] cp, input int len, input int keep);
      logic [7:0]    enc [0:3];
      text_byte_type item;
      enc = '{default: 8'h00};
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) begin
         item.b   = enc[i];
         item.fin = 1'b0;
         text_q   = {text_q, item};
      end
   endtask

   // Mostly well-formed characters with random content, the rest malformed.
   task automatic build_text();
      int            n;
      int            kind;
      int            len;
      logic [20:0]   cp;
      text_byte_type item;
      n = $urandom_range(10, 1);
      repeat (n) begin
         kind = $urandom_range(99);
         if (kind < 25) begin
            add_code(21'($urandom_range(8'h7E, 8'h20)), 1, 1);
         end else if (kind < 33) begin
            cp = ($urandom_range(4) == 0) ? 21'h7F : 21'($urandom_range(31));
            add_code(cp, 1, 1);
         end else if (kind < 45) begin
            case ($urandom_range(2))
               0:       cp = 21'($urandom_range(21'h9F, 21'h80));
               1:       cp = 21'($urandom_range(21'h36F, 21'h300));
               default: cp = 21'($urandom_range(21'h7FF, 21'h80));
            endcase
            add_code(cp, 2, 2);
         end else if (kind < 60) begin
            case ($urandom_range(3))
               0:       cp = 21'($urandom_range(21'h9FFF, 21'h4E00));
               1:       cp = 21'($urandom_range(21'hFE0F, 21'hFE00));
               2:       cp = 21'($urandom_range(21'hDFFF, 21'hD800));
               default: cp = 21'($urandom_range(21'hFFFF, 21'h800));
            endcase
            add_code(cp, 3, 3);
         end else if (kind < 70) begin
            case ($urandom_range(2))
               0:       cp = 21'($urandom_range(21'h1FAFF, 21'h1F300));
               1:       cp = 21'($urandom_range(21'h3FFFD, 21'h20000));
               default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            endcase
            add_code(cp, 4, 4);
         end else if (kind < 78) begin
            len = $urandom_range(4, 2);
            cp  = 21'($urandom_range(len == 2 ? 21'h7F : len == 3 ? 21'h7FF : 21'hFFFF));
            add_code(cp, len, len);
         end else if (kind < 84) begin
            add_code(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
         end else if (kind < 92) begin
            len = $urandom_range(4, 2);
            cp  = (len == 2) ? 21'($urandom_range(21'h7FF, 21'h80)) :
                  (len == 3) ? 21'($urandom_range(21'hFFFF, 21'h800)) :
                               21'($urandom_range(21'h10FFFF, 21'h10000));
            add_code(cp, len, $urandom_range(len - 1, 1));
         end else begin
            item.b   = 8'($urandom_range(255));
            item.fin = 1'b0;
            text_q   = {text_q, item};
         end
      end
      item = text_q[text_q.size() - 1];
      item.fin = 1'b1;
      text_q[text_q.size() - 1] = item;
   endtask

   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.in_byte  <= 8'h00;
      req_chan.text_end <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_seq[i]) send(directed_seq[i][7:0], directed_seq[i][8]);
      // Hold off until every result of the directed part is back.
      wait_drained();

      while (text_q.size() < RANDOM_ITEMS) build_text();
      foreach (text_q[i]) send(text_q[i].b, text_q[i].fin);
      wait_drained();

      // A text of C1 escapes, the longest expansion, ends on a wide character.
      for (int k = 0; k < C1_PAIRS; k++) begin
         send(8'hC2, 1'b0);
         send(8'($urandom_range(8'h9F, 8'h80)), 1'b0);
      end
      send(8'hE4, 1'b0);
      send(8'hB8, 1'b0);
      send(8'h80, 1'b1);
      wait_drained();

      $display("Sent %0d requests: directed cases, %0d random text bytes, C1 escapes.",
               req_seen, text_q.size());
      $display("Compared %0d result bytes against the predicted stream.", rsp_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Timed out with %0d results outstanding.", pending);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
